[hdl/sidta_pkg.sv]
package sidta_pkg;

	localparam int MAG_W = 32;
	localparam int DIGIT_W = 4;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W = NUM_DIGITS * DIGIT_W;
	localparam int CNT_W = $clog2(MAG_W);
	localparam int NDIG_W = $clog2(NUM_DIGITS + 1);
	localparam int CHAR_W = 6;

	localparam logic [CHAR_W-1:0] CODE_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);
	localparam logic [NDIG_W-1:0] NDIG_FULL = NDIG_W'(NUM_DIGITS);
	localparam logic [NDIG_W-1:0] NDIG_ONE = NDIG_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

endpackage

[hdl/signed_int_to_decimal_ascii_top.sv]
// channel  dir  tvalid/tready        tdata (low bit up)                 tuser  tlast
// s_       in   s_tvalid, s_tready   [31:0] value (signed)              -      -
// m_       out  m_tvalid, m_tready   [5:0] char_code, [7:6] zero        -      last
//
// input is taken only in idle; shift-and-add-3 conversion then runs over all 32 bits
// leading zeros are dropped one digit per cycle until the first nonzero or final digit
// characters leave one per cycle from the output register while m_tready is high: 1 to 11 beats
// a stall on m_tready holds the character in place; reset clears all control
// the next value can be taken while the last character still waits
module signed_int_to_decimal_ascii_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [5:0] char_code, [7:6] zero
	output logic        m_tlast
);
	import sidta_pkg::*;

	state_t state_q, state_d;

	logic [MAG_W-1:0]  mag_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NDIG_W-1:0] ndig_q;
	logic              sign_q;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	logic              in_take;
	logic              out_free;
	logic              conv_step;
	logic              skip_step;
	logic              emit_sign;
	logic              emit_digit;
	logic              top_zero;
	logic              final_digit;
	logic [BCD_W-1:0]  bcd_adj;
	logic [MAG_W-1:0]  in_mag;
	logic [DIGIT_W-1:0] top_digit;

	assign in_take     = s_tvalid && s_tready;
	assign out_free    = !out_valid_q || m_tready;
	assign top_digit   = bcd_q[BCD_W-1 -: DIGIT_W];
	assign top_zero    = (top_digit == '0);
	assign final_digit = (ndig_q == NDIG_ONE);
	assign in_mag      = s_tdata[MAG_W-1] ? (MAG_W'(0) - s_tdata) : s_tdata;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == '0) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (!top_zero || final_digit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && !sign_q && final_digit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready   = 1'b0;
		conv_step  = 1'b0;
		skip_step  = 1'b0;
		emit_sign  = 1'b0;
		emit_digit = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_CONV: conv_step = 1'b1;
			ST_SKIP: skip_step = top_zero && !final_digit;
			ST_EMIT: begin
				emit_sign  = out_free && sign_q;
				emit_digit = out_free && !sign_q;
			end
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ndig_q  <= '0;
			sign_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				cnt_q  <= CNT_LAST;
				ndig_q <= NDIG_FULL;
				sign_q <= s_tdata[MAG_W-1];
			end else begin
				if (conv_step) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				if (skip_step || emit_digit) begin
					ndig_q <= ndig_q - NDIG_ONE;
				end
				if (emit_sign) begin
					sign_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mag_q <= in_mag;
			bcd_q <= '0;
		end else if (conv_step) begin
			{bcd_q, mag_q} <= {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
		end else if (skip_step || emit_digit) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_sign || emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_sign) begin
			out_char_q <= CODE_MINUS;
			out_last_q <= 1'b0;
		end else if (emit_digit) begin
			out_char_q <= CODE_ZERO + CHAR_W'(top_digit);
			out_last_q <= final_digit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_char_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_CONV) && (cnt_q == CNT_LAST))
		else $error("conversion did not start after a beat was taken");

	a_ndig_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (ndig_q != '0) && (ndig_q <= NDIG_FULL))
		else $error("digit count out of range while emitting");

	a_digit_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (top_digit <= DIGIT_W'(9)))
		else $error("non-decimal digit reached the output");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[CHAR_W-1:0] == CODE_MINUS)) |-> !m_tlast)
		else $error("minus sign marked as last beat");
`endif

endmodule

[bench/signed_int_to_decimal_ascii_top_test.sv]
module signed_int_to_decimal_ascii_top_test;
	import sidta_pkg::*;

	localparam int DIR_N = 20;
	localparam int RAND_N = 130;
	localparam int CALM_N = 30;
	localparam int DEC_BASE = 10;
	localparam int LONG_HOLD = 400;
	localparam int HOLD_AT = 1500;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} ascii_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	ascii_beat_t expected_chars[$];
	ascii_beat_t want;
	int          mismatches = 0;
	int          chars_seen = 0;
	int          cycle_count = 0;
	bit          calm_phase = 1'b0;
	bit          held_off = 1'b0;

	// directed values; text is typed in only where it is obvious, else predicted
	logic [31:0] dir_values [DIR_N] = '{
		32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, -32'sd100,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
		32'd999999999, -32'sd999999999, 32'd1234567890, 32'h5555_5555,
		32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'd7, -32'sd5
	};
	string dir_text [DIR_N] = '{
		"0", "1", "-1", "", "", "", "", "",
		"2147483647", "-2147483648", "", "",
		"", "", "", "",
		"", "-2", "", ""
	};

	signed_int_to_decimal_ascii_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// decimal text of one value, most significant digit first, no leading zeros
	function automatic void predict_decimal_text(input logic [31:0] value);
		logic [31:0] mag;
		logic [3:0]  digit [10];
		int          nd;
		mag = value[31] ? -value : value;
		nd = 0;
		do begin
			digit[nd] = 4'(mag % DEC_BASE);
			mag = mag / DEC_BASE;
			nd++;
		end while (mag != 0);
		if (value[31])
			expected_chars.push_back(ascii_beat_t'{code: CODE_MINUS, last: 1'b0});
		for (int i = nd - 1; i >= 0; i--)
			expected_chars.push_back(ascii_beat_t'{code: CODE_ZERO + CHAR_W'(digit[i]),
				last: (i == 0)});
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: char %0d last %0b with nothing expected",
					$time, m_tdata[5:0], m_tlast);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				chars_seen++;
				if (m_tdata[5:0] !== want.code) begin
					$display("%0t: char_code expected %0d, got %0d",
						$time, want.code, m_tdata[5:0]);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last expected %0b, got %0b", $time, want.last, m_tlast);
					mismatches++;
				end
				if (m_tdata[7:6] !== 2'b00) begin
					$display("%0t: pad bits expected 0, got %b", $time, m_tdata[7:6]);
					mismatches++;
				end
			end
		end
	end

	// output side: random stall bursts, one long hold so the converter backs up
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!calm_phase && !held_off && cycle_count >= HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				held_off = 1'b1;
			end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [31:0] value;
		logic [31:0] ten_pow;
		int          kind;
		int          total;
		total = DIR_N + RAND_N;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < total; n++) begin
			if (n >= total - CALM_N)
				calm_phase = 1'b1;
			if (n < DIR_N) begin
				value = dir_values[n];
			end else begin
				kind = $urandom_range(0, 4);
				case (kind)
				0: value = $urandom;
				1: value = $urandom_range(0, 99);
				2: begin
					// around a power of ten, where the digit count changes
					ten_pow = 1;
					repeat ($urandom_range(0, 9)) ten_pow = ten_pow * DEC_BASE;
					value = ten_pow + $urandom_range(0, 2) - 1;
				end
				3: value = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
					: 32'h8000_0000 + $urandom_range(0, 15);
				default: value = $urandom >> $urandom_range(0, 31);
				endcase
				if (kind != 3 && $urandom_range(0, 1) == 1)
					value = -value;
			end
			if (!calm_phase && $urandom_range(0, 2) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= value;
			do @(posedge clk); while (!s_tready);
			if (n < DIR_N && dir_text[n].len() != 0) begin
				for (int c = 0; c < dir_text[n].len(); c++)
					expected_chars.push_back(ascii_beat_t'{code: CHAR_W'(dir_text[n][c]),
						last: (c == dir_text[n].len() - 1)});
			end else begin
				predict_decimal_text(value);
			end
		end
		s_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			$display("%0t: %0d characters never arrived", $time, expected_chars.size());
			mismatches++;
		end
		$display("covered %0d values (%0d characters), incl. zero, both extremes,",
			total, chars_seen);
		$display("power-of-ten edges and a %0d-cycle output hold", LONG_HOLD);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
